/* rtl/u8d_pkg.sv */
`timescale 1ns / 1ps

package u8d_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int LEN_W  = 3;
   localparam int REM_W  = 2;

   // Lead and continuation byte prefixes
   localparam logic [BYTE_W-1:0] FIRST_LEAD  = 8'hC0;
   localparam logic [2:0]        LEAD2_MARK  = 3'b110;
   localparam logic [3:0]        LEAD3_MARK  = 4'b1110;
   localparam logic [4:0]        LEAD4_MARK  = 5'b11110;
   localparam logic [1:0]        CONT_MARK   = 2'b10;

   // Sequence lengths
   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_ONE  = 3'd1;
   localparam logic [LEN_W-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
   localparam logic [LEN_W-1:0] LEN_FOUR = 3'd4;

   // Continuation bytes still expected
   localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
   localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
   localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
   localparam logic [REM_W-1:0] REM_THREE = 2'd3;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      logic             bad_sequence;
   } result_type;

   // Handshake between the decode stage and the response register
   typedef struct packed {
      logic step;       // decode stage consumes its byte this cycle
      logic has_result; // the byte in the decode stage yields a result
   } stage_ctrl_type;

endpackage

/* rtl/u8d_stream_if.sv */
`timescale 1ns / 1ps

interface u8d_req_if;
   logic                       valid;
   logic                       ready;
   logic [u8d_pkg::BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface u8d_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [u8d_pkg::CP_W-1:0]  code_point;
   logic [u8d_pkg::LEN_W-1:0] seq_length;
   logic                      bad_sequence;

   modport source (output valid, output code_point, output seq_length,
                   output bad_sequence, input ready);
   modport sink   (input valid, input code_point, input seq_length,
                   input bad_sequence, output ready);
endinterface

/* rtl/u8d_decode.sv */
`timescale 1ns / 1ps

module u8d_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [u8d_pkg::BYTE_W-1:0] data_byte,
   output logic                       has_result,
   output u8d_pkg::result_type        result
);

   logic [u8d_pkg::CP_W-1:0]  partial_ff, partial_in;
   logic [u8d_pkg::REM_W-1:0] remaining_ff, remaining_in;
   logic [u8d_pkg::LEN_W-1:0] total_ff, total_in;
   logic [u8d_pkg::CP_W-1:0]  shifted;

   assign shifted = {partial_ff[u8d_pkg::CP_W-7:0], data_byte[5:0]};

   always_comb begin
      partial_in   = partial_ff;
      remaining_in = remaining_ff;
      total_in     = total_ff;
      has_result   = 1'b0;
      result       = '{code_point: '0, seq_length: u8d_pkg::LEN_NONE, bad_sequence: 1'b0};
      if (remaining_ff == u8d_pkg::REM_NONE) begin
         if (data_byte < u8d_pkg::FIRST_LEAD) begin
            has_result        = 1'b1;
            result.code_point = {{(u8d_pkg::CP_W-u8d_pkg::BYTE_W){1'b0}}, data_byte};
            result.seq_length = u8d_pkg::LEN_ONE;
         end else if (data_byte[7:5] == u8d_pkg::LEAD2_MARK) begin
            partial_in   = {{(u8d_pkg::CP_W-5){1'b0}}, data_byte[4:0]};
            remaining_in = u8d_pkg::REM_ONE;
            total_in     = u8d_pkg::LEN_TWO;
         end else if (data_byte[7:4] == u8d_pkg::LEAD3_MARK) begin
            partial_in   = {{(u8d_pkg::CP_W-4){1'b0}}, data_byte[3:0]};
            remaining_in = u8d_pkg::REM_TWO;
            total_in     = u8d_pkg::LEN_THREE;
         end else if (data_byte[7:3] == u8d_pkg::LEAD4_MARK) begin
            partial_in   = {{(u8d_pkg::CP_W-3){1'b0}}, data_byte[2:0]};
            remaining_in = u8d_pkg::REM_THREE;
            total_in     = u8d_pkg::LEN_FOUR;
         end else begin
            has_result          = 1'b1;
            result.bad_sequence = 1'b1;
         end
      end else if (data_byte[7:6] != u8d_pkg::CONT_MARK) begin
         // drop the offending byte along with the partial sequence
         has_result          = 1'b1;
         result.bad_sequence = 1'b1;
         partial_in          = '0;
         remaining_in        = u8d_pkg::REM_NONE;
         total_in            = u8d_pkg::LEN_NONE;
      end else if (remaining_ff == u8d_pkg::REM_ONE) begin
         has_result        = 1'b1;
         result.code_point = shifted;
         result.seq_length = total_ff;
         partial_in        = '0;
         remaining_in      = u8d_pkg::REM_NONE;
         total_in          = u8d_pkg::LEN_NONE;
      end else begin
         partial_in   = shifted;
         remaining_in = remaining_ff - u8d_pkg::REM_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         remaining_ff <= u8d_pkg::REM_NONE;
         total_ff     <= u8d_pkg::LEN_NONE;
      end else if (step) begin
         partial_ff   <= partial_in;
         remaining_ff <= remaining_in;
         total_ff     <= total_in;
      end
   end

   a_open_matches_total: assert property (@(posedge clock) disable iff (reset)
      (remaining_ff == u8d_pkg::REM_NONE) == (total_ff == u8d_pkg::LEN_NONE))
      else $error("sequence length and remaining count disagree");

   a_total_exceeds_remaining: assert property (@(posedge clock) disable iff (reset)
      (remaining_ff != u8d_pkg::REM_NONE) |-> ({1'b0, remaining_ff} < total_ff))
      else $error("remaining count not below sequence length");

   a_good_length: assert property (@(posedge clock) disable iff (reset)
      (has_result && !result.bad_sequence) |->
      (result.seq_length != u8d_pkg::LEN_NONE && result.seq_length <= u8d_pkg::LEN_FOUR))
      else $error("good result with impossible length");

   a_error_zeroed: assert property (@(posedge clock) disable iff (reset)
      (has_result && result.bad_sequence) |->
      (result.code_point == '0 && result.seq_length == u8d_pkg::LEN_NONE))
      else $error("error result carries payload");

endmodule

/* rtl/u8d_rsp_reg.sv */
`timescale 1ns / 1ps

module u8d_rsp_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  u8d_pkg::stage_ctrl_type ctrl,
   input  u8d_pkg::result_type     result,
   output logic                    free,
   u8d_rsp_if.source               rsp_chan
);

   logic                valid_ff, valid_in;
   u8d_pkg::result_type data_ff;
   logic                load;

   assign free     = !valid_ff || rsp_chan.ready;
   assign load     = ctrl.step && ctrl.has_result;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_chan.valid        = valid_ff;
   assign rsp_chan.code_point   = data_ff.code_point;
   assign rsp_chan.seq_length   = data_ff.seq_length;
   assign rsp_chan.bad_sequence = data_ff.bad_sequence;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (!valid_ff || rsp_chan.ready))
      else $error("response register overwritten while held");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_idle_step_keeps: assert property (@(posedge clock) disable iff (reset)
      (ctrl.step && !ctrl.has_result && valid_ff && !rsp_chan.ready) |=> valid_ff)
      else $error("held result lost on a silent step");

endmodule

/* rtl/utf8_stream_decoder_unit.sv */
`timescale 1ns / 1ps

// Channel   | Dir | Payload                                        | Handshake
// ----------+-----+------------------------------------------------+-----------
// req_chan  | in  | data_byte[7:0]                                 | valid/ready
// rsp_chan  | out | code_point[20:0], seq_length[2:0], bad_sequence| valid/ready
//
// One byte per clock while no result waits on a held response: a byte is captured
// in the input register, is decoded there against the sequence state, and its
// result (if any) is then registered in the response register.
// Reset is synchronous and closes any open sequence.
// A held response stalls only bytes that produce a result; lead and middle
// continuation bytes keep flowing while the response waits.
module utf8_stream_decoder_unit (
   input  logic      clock,
   input  logic      reset,
   u8d_req_if.sink   req_chan,
   u8d_rsp_if.source rsp_chan
);

   // input register
   logic                       in_valid_ff, in_valid_in;
   logic [u8d_pkg::BYTE_W-1:0] in_byte_ff;

   u8d_pkg::stage_ctrl_type ctrl;
   u8d_pkg::result_type     result;
   logic                    has_result;
   logic                    rsp_free;
   logic                    advance;
   logic                    accept;

   // advance the decode stage unless its result would hit a held response
   assign advance     = !has_result || rsp_free;
   assign ctrl.step   = in_valid_ff && advance;
   assign ctrl.has_result = has_result;

   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_valid_in    = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // hold the byte while stalled, capture a new transaction otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_chan.data_byte;
      end
   end

   u8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step       (ctrl.step),
      .data_byte  (in_byte_ff),
      .has_result (has_result),
      .result     (result)
   );

   u8d_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .result   (result),
      .free     (rsp_free),
      .rsp_chan (rsp_chan)
   );

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("stalled byte not held");

   a_no_step_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !ctrl.step)
      else $error("decode stepped without a byte");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted transaction not registered");

endmodule
